/* rtl/core/brx_pkg.sv */
// ----------------------------------------------------------------------------
// brx_pkg
// Shared types and constants for the block run extent builder.
// ----------------------------------------------------------------------------
package brx_pkg;

    localparam int BLOCK_BITS_DEF = 32;   // default width of a block number

    localparam int IN_BLK_W   = 32;       // block_number field width
    localparam int BASE_W     = 32;       // base_sector register width
    localparam int SPB_W      = 8;        // sectors per block register width
    localparam int MAXE_W     = 16;       // max_extents register width
    localparam int LEN_W      = 32;       // run length width (saturating)
    localparam int OUT_W      = 40;       // extent_start / extent_sectors width
    localparam int OUT_DATA_W = 2 * OUT_W;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 32;

    localparam int NUM_SLOTS  = 3;        // most results one item can cause
    localparam int SLOT_W     = $clog2(NUM_SLOTS + 1);

    localparam logic [CFG_ADDR_W-1:0] REG_BASE_SECTOR = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_BLK_SECTORS = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_EXTENTS = 2'd2;

    localparam logic [BASE_W-1:0] BASE_RST = '0;
    localparam logic [SPB_W-1:0]  SPB_RST  = 8'd2;
    localparam logic [MAXE_W-1:0] MAXE_RST = 16'd64;

    localparam logic [LEN_W-1:0]  LEN_MAX  = '1;

    typedef struct packed {
        logic [BASE_W-1:0] base_sector;
        logic [SPB_W-1:0]  blk_sectors;
        logic [MAXE_W-1:0] max_extents;
    } t_cfg;

    typedef struct packed {
        logic [OUT_W-1:0] extent_start;
        logic [OUT_W-1:0] extent_sectors;
        logic             overflow;
        logic             end_of_list;
    } t_result;

    typedef struct packed {
        logic [SLOT_W-1:0] count;
        t_result [NUM_SLOTS-1:0] slot;
    } t_bundle;

endpackage

/* rtl/core/brx_cfg_regs.sv */
// ----------------------------------------------------------------------------
// brx_cfg_regs
// Configuration register file: base sector, sectors per block, list capacity.
// ----------------------------------------------------------------------------
module brx_cfg_regs import brx_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_BASE_SECTOR: n_cfg.base_sector = BASE_W'(i_cfg_wdata);
                REG_BLK_SECTORS: n_cfg.blk_sectors = SPB_W'(i_cfg_wdata);
                REG_MAX_EXTENTS: n_cfg.max_extents = MAXE_W'(i_cfg_wdata);
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.base_sector <= BASE_RST;
            r_cfg.blk_sectors <= SPB_RST;
            r_cfg.max_extents <= MAXE_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* rtl/core/brx_run_tracker.sv */
// ----------------------------------------------------------------------------
// brx_run_tracker
// Input register, run state and the single-pass extent logic. Produces the
// bundle of results (zero to three) caused by the registered item.
// ----------------------------------------------------------------------------
module brx_run_tracker import brx_pkg::*; #(
    parameter int BLOCK_BITS = BLOCK_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cfg                i_cfg,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [IN_BLK_W-1:0] i_in_block,
    input  logic                i_in_final,
    input  logic                i_room,
    output logic                o_push,
    output t_bundle             o_bundle
);

    localparam int BW = BLOCK_BITS;
    localparam int PW = BW + SPB_W;                 // start * spb product
    localparam int SW = (PW + 1 > OUT_W) ? PW + 1 : OUT_W;

    // input register
    logic                r_iv;
    logic [IN_BLK_W-1:0] r_blk;
    logic                r_fin;

    // run state
    logic              r_started;
    logic [BW-1:0]     r_prev;
    logic [BW-1:0]     r_rs;
    logic [LEN_W-1:0]  r_rl;
    logic [MAXE_W-1:0] r_ew;
    logic              r_err;

    logic              n_started;
    logic [BW-1:0]     n_prev;
    logic [BW-1:0]     n_rs;
    logic [LEN_W-1:0]  n_rl;
    logic [MAXE_W-1:0] n_ew;
    logic              n_err;

    logic [BW-1:0]     blk;
    logic              adj;
    logic              brk;
    logic              brk_ovf;
    logic [BW-1:0]     run_rs;
    logic [LEN_W-1:0]  run_rl;
    logic [MAXE_W-1:0] ew1;
    logic              take;

    logic [PW-1:0]     brk_prod;
    logic [PW-1:0]     fin_prod;
    t_result           e_break;
    t_result           e_final;
    t_result           e_term;
    t_result           e_ovf;
    t_bundle           bundle;

    assign blk = BW'(r_blk);

    assign adj = r_started && (r_prev != {BW{1'b1}}) && (blk == r_prev + BW'(1));
    assign brk = r_started && !adj;
    assign brk_ovf = brk && (r_ew >= i_cfg.max_extents);

    // run after this item (before any end-of-file clear)
    always_comb begin
        if (!r_started || brk) begin
            run_rs = blk;
            run_rl = LEN_W'(1);
        end else begin
            run_rs = r_rs;
            run_rl = (r_rl == LEN_MAX) ? r_rl : r_rl + LEN_W'(1);
        end
    end

    assign ew1 = brk ? r_ew + MAXE_W'(1) : r_ew;

    // extent arithmetic
    assign brk_prod = PW'(r_rs) * PW'(i_cfg.blk_sectors);
    assign fin_prod = PW'(run_rs) * PW'(i_cfg.blk_sectors);

    always_comb begin
        e_break.extent_start   = OUT_W'(SW'(brk_prod) + SW'(i_cfg.base_sector));
        e_break.extent_sectors = OUT_W'(r_rl) * OUT_W'(i_cfg.blk_sectors);
        e_break.overflow       = 1'b0;
        e_break.end_of_list    = 1'b0;

        e_final.extent_start   = OUT_W'(SW'(fin_prod) + SW'(i_cfg.base_sector));
        e_final.extent_sectors = OUT_W'(run_rl) * OUT_W'(i_cfg.blk_sectors);
        e_final.overflow       = 1'b0;
        e_final.end_of_list    = 1'b0;

        e_term = '0;
        e_term.end_of_list = 1'b1;

        e_ovf = '0;
        e_ovf.overflow    = 1'b1;
        e_ovf.end_of_list = 1'b1;
    end

    // result list for the registered item
    always_comb begin
        bundle = '0;
        if (!r_err) begin
            if (brk_ovf) begin
                bundle.count   = SLOT_W'(1);
                bundle.slot[0] = e_ovf;
            end else if (brk) begin
                bundle.slot[0] = e_break;
                if (!r_fin) begin
                    bundle.count = SLOT_W'(1);
                end else if (ew1 >= i_cfg.max_extents) begin
                    bundle.count   = SLOT_W'(2);
                    bundle.slot[1] = e_ovf;
                end else begin
                    bundle.count   = SLOT_W'(3);
                    bundle.slot[1] = e_final;
                    bundle.slot[2] = (ew1 + MAXE_W'(1) >= i_cfg.max_extents) ? e_ovf : e_term;
                end
            end else if (r_fin) begin
                bundle.count = SLOT_W'(2);
                if (ew1 >= i_cfg.max_extents) begin
                    bundle.count   = SLOT_W'(1);
                    bundle.slot[0] = e_ovf;
                end else begin
                    bundle.slot[0] = e_final;
                    bundle.slot[1] = (ew1 + MAXE_W'(1) >= i_cfg.max_extents) ? e_ovf : e_term;
                end
            end
        end
    end

    // items with no result need no room downstream
    assign take       = r_iv && ((bundle.count == '0) || i_room);
    assign o_in_ready = !r_iv || take;
    assign o_push     = take;
    assign o_bundle   = bundle;

    // next run state
    always_comb begin
        n_started = r_started;
        n_prev    = r_prev;
        n_rs      = r_rs;
        n_rl      = r_rl;
        n_ew      = r_ew;
        n_err     = r_err;
        if (take) begin
            if (!r_err) begin
                if (brk_ovf) begin
                    n_err = 1'b1;
                end else begin
                    n_started = 1'b1;
                    n_prev    = blk;
                    n_rs      = run_rs;
                    n_rl      = run_rl;
                    n_ew      = ew1;
                end
            end
            if (r_fin) begin
                n_started = 1'b0;
                n_prev    = '0;
                n_rs      = '0;
                n_rl      = '0;
                n_ew      = '0;
                n_err     = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv      <= 1'b0;
            r_started <= 1'b0;
            r_prev    <= '0;
            r_rs      <= '0;
            r_rl      <= '0;
            r_ew      <= '0;
            r_err     <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                r_iv <= 1'b1;
            end else if (take) begin
                r_iv <= 1'b0;
            end
            r_started <= n_started;
            r_prev    <= n_prev;
            r_rs      <= n_rs;
            r_rl      <= n_rl;
            r_ew      <= n_ew;
            r_err     <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_blk <= i_in_block;
            r_fin <= i_in_final;
        end
    end

endmodule

/* rtl/core/brx_result_buf.sv */
// ----------------------------------------------------------------------------
// brx_result_buf
// Result register bank: holds the results of one item and hands them out
// one per cycle on the output stream while the output is ready.
// ----------------------------------------------------------------------------
module brx_result_buf import brx_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_bundle i_bundle,
    output logic    o_room,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    t_result [NUM_SLOTS-1:0] r_res;
    logic [SLOT_W-1:0]       r_cnt;
    logic [SLOT_W-1:0]       r_idx;
    logic [SLOT_W-1:0]       n_cnt;
    logic [SLOT_W-1:0]       n_idx;

    logic pop;
    logic last_pop;
    logic load;

    assign o_valid  = (r_cnt != '0);
    assign pop      = o_valid && i_ready;
    assign last_pop = pop && (r_idx == r_cnt - SLOT_W'(1));
    assign o_room   = !o_valid || last_pop;
    assign load     = i_push && (i_bundle.count != '0);

    always_comb begin
        n_cnt = r_cnt;
        n_idx = r_idx;
        if (load) begin
            n_cnt = i_bundle.count;
            n_idx = '0;
        end else if (last_pop) begin
            n_cnt = '0;
            n_idx = '0;
        end else if (pop) begin
            n_idx = r_idx + SLOT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_idx <= '0;
        end else begin
            r_cnt <= n_cnt;
            r_idx <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res <= i_bundle.slot;
        end
    end

    assign o_result = r_res[r_idx[$clog2(NUM_SLOTS)-1:0]];

endmodule

/* rtl/core/block_run_extent_builder.sv */
// ----------------------------------------------------------------------------
// block_run_extent_builder
// Merges runs of consecutive filesystem block numbers into disk extents.
// ----------------------------------------------------------------------------
// Takes one block number per cycle unless an item with results must wait for
// room in the result register bank. An item enters an input register, where
// it is compared with the previous block; when taken, it updates the run state
// and loads its results, if any, into the result register bank, which drives
// the output. Items that cause no result or one result flow at one per cycle
// while the output does not stall. The final item of a file causes up to three
// results (closing extent of a broken run, final extent, terminator), which
// leave the result register bank one per cycle while the output is ready; an
// item behind it that has results of its own waits in the input register until
// the last of them is taken. Items with no result never wait for the output.
// Output tdata carries extent_start in bits [39:0] and extent_sectors in
// [79:40]; tuser is the overflow flag and tlast marks the last result of a
// file. Configuration must only be written while the block is idle.
// ----------------------------------------------------------------------------
module block_run_extent_builder import brx_pkg::*; #(
    parameter int BLOCK_BITS = BLOCK_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // block numbers in
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [IN_BLK_W-1:0]   i_s_axis_tdata,   // [31:0] block_number
    input  logic                  i_s_axis_tlast,   // is_final
    // extents out
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,   // [39:0] extent_start,
                                                    // [79:40] extent_sectors
    output logic                  o_m_axis_tuser,   // overflow
    output logic                  o_m_axis_tlast    // end_of_list
);

    t_cfg    cfg;
    t_bundle bundle;
    t_result result;
    logic    push;
    logic    room;

    brx_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    brx_run_tracker #(
        .BLOCK_BITS (BLOCK_BITS)
    ) u_tracker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_in_block (i_s_axis_tdata),
        .i_in_final (i_s_axis_tlast),
        .i_room     (room),
        .o_push     (push),
        .o_bundle   (bundle)
    );

    brx_result_buf u_result (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_bundle (bundle),
        .o_room   (room),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_result (result)
    );

    assign o_m_axis_tdata = {result.extent_sectors, result.extent_start};
    assign o_m_axis_tuser = result.overflow;
    assign o_m_axis_tlast = result.end_of_list;

endmodule

/* sim/brx_checker.sv */
// ----------------------------------------------------------------------------
// brx_checker
// Watches the block-number and extent channels of the run extent builder,
// keeps its own run/extent state and compares each extent against it.
// ----------------------------------------------------------------------------
module brx_checker import brx_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_blk_valid,
    input  logic                  i_blk_ready,
    input  logic [IN_BLK_W-1:0]   i_blk_data,
    input  logic                  i_blk_last,
    input  logic                  i_ext_valid,
    input  logic                  i_ext_ready,
    input  logic [OUT_DATA_W-1:0] i_ext_data,
    input  logic                  i_ext_user,
    input  logic                  i_ext_last,
    output int                    o_pending,
    output int                    o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [BASE_W-1:0]   base_sec;
    logic [SPB_W-1:0]    spb;
    logic [MAXE_W-1:0]   cap;

    logic                file_open;
    logic [IN_BLK_W-1:0] last_block;
    logic [IN_BLK_W-1:0] run_first;
    logic [LEN_W-1:0]    run_blocks;
    logic [MAXE_W-1:0]   entries_used;
    logic                list_failed;

    t_result extent_queue[$];
    int      fails = 0;

    task automatic clear_file_state();
        file_open    = 1'b0;
        last_block   = '0;
        run_first    = '0;
        run_blocks   = '0;
        entries_used = '0;
        list_failed  = 1'b0;
    endtask

    // one list entry, or the overflow marker once the list is full
    task automatic queue_entry(input logic [OUT_W-1:0] sec_start, input logic [OUT_W-1:0] sec_len,
                               input logic eol, output logic ok);
        t_result r;
        if (entries_used >= cap) begin
            r             = '0;
            r.overflow    = 1'b1;
            r.end_of_list = 1'b1;
            list_failed   = 1'b1;
            ok            = 1'b0;
        end else begin
            r.extent_start   = sec_start;
            r.extent_sectors = sec_len;
            r.overflow       = 1'b0;
            r.end_of_list    = eol;
            entries_used++;
            ok = 1'b1;
        end
        extent_queue.push_back(r);
    endtask

    task automatic queue_run(output logic ok);
        logic [63:0] sec_first;
        logic [63:0] sec_count;
        sec_first = {32'd0, base_sec} + {32'd0, run_first} * {56'd0, spb};
        sec_count = {32'd0, run_blocks} * {56'd0, spb};
        queue_entry(sec_first[OUT_W-1:0], sec_count[OUT_W-1:0], 1'b0, ok);
    endtask

    task automatic coalesce_block(input logic [IN_BLK_W-1:0] blk, input logic fin);
        logic ok;
        // rest of a failed file is dropped; its final item closes it
        if (list_failed) begin
            if (fin)
                clear_file_state();
            return;
        end
        if (!file_open) begin
            file_open  = 1'b1;
            run_first  = blk;
            run_blocks = 1;
        end else if (last_block != '1 && blk == last_block + 1'b1) begin
            if (run_blocks != LEN_MAX)
                run_blocks++;
        end else begin
            queue_run(ok);
            if (!ok) begin
                if (fin)
                    clear_file_state();
                return;
            end
            run_first  = blk;
            run_blocks = 1;
        end
        last_block = blk;
        if (fin) begin
            queue_run(ok);
            if (ok)
                queue_entry('0, '0, 1'b1, ok);
            clear_file_state();
        end
    endtask

    task automatic compare_result();
        t_result want;
        if (extent_queue.size() == 0) begin
            fails++;
            $display("%0t: unexpected extent start=%h sectors=%h overflow=%b end=%b",
                     $time, i_ext_data[OUT_W-1:0], i_ext_data[OUT_DATA_W-1:OUT_W],
                     i_ext_user, i_ext_last);
            return;
        end
        want = extent_queue.pop_front();
        if (i_ext_data[OUT_W-1:0] !== want.extent_start) begin
            fails++;
            $display("%0t: extent_start expected %h, actual %h",
                     $time, want.extent_start, i_ext_data[OUT_W-1:0]);
        end
        if (i_ext_data[OUT_DATA_W-1:OUT_W] !== want.extent_sectors) begin
            fails++;
            $display("%0t: extent_sectors expected %h, actual %h",
                     $time, want.extent_sectors, i_ext_data[OUT_DATA_W-1:OUT_W]);
        end
        if (i_ext_user !== want.overflow) begin
            fails++;
            $display("%0t: overflow expected %b, actual %b", $time, want.overflow, i_ext_user);
        end
        if (i_ext_last !== want.end_of_list) begin
            fails++;
            $display("%0t: end_of_list expected %b, actual %b",
                     $time, want.end_of_list, i_ext_last);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            base_sec = BASE_RST;
            spb      = SPB_RST;
            cap      = MAXE_RST;
            clear_file_state();
            extent_queue.delete();
        end else begin
            if (i_ext_valid && i_ext_ready)
                compare_result();
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_BASE_SECTOR: base_sec = i_cfg_wdata[BASE_W-1:0];
                    REG_BLK_SECTORS: spb      = i_cfg_wdata[SPB_W-1:0];
                    REG_MAX_EXTENTS: cap      = i_cfg_wdata[MAXE_W-1:0];
                    default: ;
                endcase
            end
            if (i_blk_valid && i_blk_ready)
                coalesce_block(i_blk_data, i_blk_last);
        end
        o_pending    <= extent_queue.size();
        o_fail_count <= fails;
    end

endmodule

/* sim/tb_block_run_extent_builder.sv */
// ----------------------------------------------------------------------------
// tb_block_run_extent_builder
// Feeds files of block numbers through the extent builder under several
// partition layouts, with random gaps on both channels and one long output
// stall; the checker compares every extent, the bench reports any mismatch.
// ----------------------------------------------------------------------------
module tb_block_run_extent_builder;
    import brx_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES = 200;
    localparam int IDLE_LIMIT  = 2000;
    localparam int PHASE_ITEMS = 22;

    logic                  clk     = 1'b0;
    logic                  rst_n   = 1'b0;
    logic                  cfg_we  = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [IN_BLK_W-1:0]   s_data  = '0;
    logic                  s_last  = 1'b0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [OUT_DATA_W-1:0] m_data;
    logic                  m_user;
    logic                  m_last;

    int pending;
    int fail_count;
    int idle_cycles  = 0;
    int phase_items  = 0;
    bit quiet        = 1'b0;   // no gaps on either side
    bit hold_req     = 1'b0;
    bit hold_active  = 1'b0;

    always #1 clk = ~clk;

    block_run_extent_builder DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tlast  (s_last),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user),
        .o_m_axis_tlast  (m_last)
    );

    brx_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_addr   (cfg_addr),
        .i_cfg_wdata  (cfg_wdata),
        .i_blk_valid  (s_valid),
        .i_blk_ready  (s_ready),
        .i_blk_data   (s_data),
        .i_blk_last   (s_last),
        .i_ext_valid  (m_valid),
        .i_ext_ready  (m_ready),
        .i_ext_data   (m_data),
        .i_ext_user   (m_user),
        .i_ext_last   (m_last),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic send_item(input logic [IN_BLK_W-1:0] blk, input logic fin);
        int gap;
        gap = gap_len();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= blk;
        s_last  <= fin;
        do @(posedge clk); while (!s_ready);
        phase_items++;
    endtask

    // let the last item land in the checker, then wait for every extent
    task automatic wait_list_done();
        s_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic set_layout(input logic [31:0] base, input logic [7:0] spb,
                              input logic [15:0] cap);
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_BASE_SECTOR;
        cfg_wdata <= base;
        @(posedge clk);
        cfg_addr  <= REG_BLK_SECTORS;
        cfg_wdata <= {24'd0, spb};
        @(posedge clk);
        cfg_addr  <= REG_MAX_EXTENTS;
        cfg_wdata <= {16'd0, cap};
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [IN_BLK_W-1:0] jump_block();
        case ($urandom_range(0, 2))
            0:       return $urandom();
            1:       return $urandom_range(0, 1000);
            default: return 32'hFFFF_FFFF - $urandom_range(0, 4);
        endcase
    endfunction

    task automatic send_random_file(input int len);
        logic [IN_BLK_W-1:0] blk;
        blk = jump_block();
        for (int i = 0; i < len; i++) begin
            if (i != 0)
                blk = ($urandom_range(0, 99) < 40) ? jump_block() : blk + 1'b1;
            send_item(blk, i == len - 1);
        end
    endtask

    // output side: random stalls, plus a long hold-off on request
    initial begin
        int n;
        forever begin
            if (hold_req) begin
                m_ready    <= 1'b0;
                hold_active = 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_active = 1'b0;
                hold_req    = 1'b0;
            end
            n = gap_len();
            if (n != 0) begin
                m_ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    end

    always @(posedge clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset layout: single block, one run, run up to the top block
        // with no wrap, break on the final item, breaks mid-file
        send_item(32'd0, 1'b1);
        send_item(32'd5, 1'b0);
        send_item(32'd6, 1'b0);
        send_item(32'd7, 1'b1);
        send_item(32'hFFFF_FFFE, 1'b0);
        send_item(32'hFFFF_FFFF, 1'b0);
        send_item(32'd0, 1'b1);
        send_item(32'd10, 1'b0);
        send_item(32'd20, 1'b1);
        send_item(32'd100, 1'b0);
        send_item(32'd200, 1'b0);
        send_item(32'd201, 1'b0);
        send_item(32'd300, 1'b1);
        wait_list_done();

        // largest sectors, capacity 2: overflow on the terminator, then
        // overflow mid-file with the rest of the file dropped
        set_layout(32'hFFFF_FFFF, 8'd255, 16'd2);
        send_item(32'hFFFF_FFFF, 1'b1);
        send_item(32'd1, 1'b0);
        send_item(32'd3, 1'b1);
        for (int i = 0; i < 5; i++)
            send_item(32'd1 + 2 * i, i == 4);
        wait_list_done();

        // zero capacity and zero sectors per block
        set_layout(32'd0, 8'd0, 16'd0);
        send_item(32'd4, 1'b1);
        wait_list_done();
        set_layout(32'd0, 8'd1, 16'd1);
        send_item(32'd4, 1'b0);
        send_item(32'd5, 1'b1);
        wait_list_done();

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: set_layout($urandom(), 8'd128, 16'd65535);
                1: set_layout(32'd0, 8'd1, 16'd65535);
                2: set_layout(32'hFFFF_FFFF, 8'd255, 16'd2);
                3: set_layout($urandom(), 8'($urandom_range(1, 128)),
                              16'($urandom_range(2, 6)));
                4: set_layout($urandom(), 8'd0, 16'd3);
                default: set_layout($urandom(), 8'($urandom_range(0, 255)),
                                    16'($urandom_range(0, 12)));
            endcase
            quiet       = (phase == 3);
            phase_items = 0;
            if (phase == 1) begin
                // output held off while a file of broken runs streams in
                hold_req = 1'b1;
                wait (hold_active);
                quiet = 1'b1;
                for (int i = 0; i < 24; i++)
                    send_item($urandom(), i == 23);
                quiet = 1'b0;
            end
            while (phase_items < PHASE_ITEMS)
                send_random_file(($urandom_range(0, 9) == 0) ? $urandom_range(9, 20)
                                                              : $urandom_range(1, 8));
            wait_list_done();
        end

        quiet = 1'b0;
        repeat (10) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

/* files.f */
rtl/core/brx_pkg.sv
rtl/core/brx_cfg_regs.sv
rtl/core/brx_run_tracker.sv
rtl/core/brx_result_buf.sv
rtl/core/block_run_extent_builder.sv
sim/brx_checker.sv
sim/tb_block_run_extent_builder.sv
